@@ rtl/icm_pkg.sv @@
// shared types and constants of the inverse colormap cache
// controller commands, status, state encoding and distance weights
// no dependencies
`default_nettype none
package icm_pkg;

  localparam int PALETTE_DEPTH_DEF   = 256;
  localparam int RED_CELL_BITS_DEF   = 5;
  localparam int GREEN_CELL_BITS_DEF = 6;
  localparam int BLUE_CELL_BITS_DEF  = 5;

  localparam int DIST_W = 20;

  localparam logic signed [10:0] RED_WT   = 11'sd2;
  localparam logic signed [10:0] GREEN_WT = 11'sd3;
  localparam logic signed [10:0] BLUE_WT  = 11'sd1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    SEL_CELL = 2'd0,
    SEL_NEAR = 2'd1,
    SEL_FAR  = 2'd2
  } unit_sel_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_P1_RD,
    ST_P1_NEAR,
    ST_P1_FAR,
    ST_P1_W1,
    ST_P1_W2,
    ST_P1_W3,
    ST_P2_RD,
    ST_P2_CHK,
    ST_F_RDC,
    ST_F_RDP,
    ST_F_RUN,
    ST_F_DRAIN,
    ST_W_RUN,
    ST_W_DRAIN,
    ST_LOOK2,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic      clr_step;
    logic      pal_write;
    logic      pix_load;
    logic      hit_latch;
    logic      p1_init;
    unit_sel_t sel;
    logic      cmin_write;
    logic      bmax_update;
    logic      ent_next;
    logic      p2_init;
    logic      cand_check;
    logic      fill_init;
    logic      pal_cand;
    logic      cell_issue;
    logic      cand_done;
    logic      wb_init;
    logic      wb_issue;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic ent_last;
    logic cell_last;
    logic pipe_busy;
    logic cand_last;
    logic wb_busy;
    logic out_free;
  } ctrl_status_t;

endpackage
`default_nettype wire

@@ rtl/icm_ctrl.sv @@
// controller state machine of the inverse colormap cache
// sequences clear, palette write, lookup, prune, box fill and write-back; uses icm_pkg
`default_nettype none
module icm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic [1:0]            in_cmd,
  output logic                       in_tready,
  input  wire icm_pkg::ctrl_status_t status,
  output icm_pkg::ctrl_cmd_t         cmd
);
  import icm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          case (cmd_code_t'(in_cmd))
            CMD_LOOKUP: state_nxt = ST_LOOK;
            CMD_CLEAR:  state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOK:    state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = status.hit ? ST_RESULT : ST_P1_RD;
      ST_P1_RD:   state_nxt = ST_P1_NEAR;
      ST_P1_NEAR: state_nxt = ST_P1_FAR;
      ST_P1_FAR:  state_nxt = ST_P1_W1;
      ST_P1_W1:   state_nxt = ST_P1_W2;
      ST_P1_W2:   state_nxt = ST_P1_W3;
      ST_P1_W3:   state_nxt = status.ent_last ? ST_P2_RD : ST_P1_RD;
      ST_P2_RD:   state_nxt = ST_P2_CHK;
      ST_P2_CHK:  state_nxt = status.ent_last ? ST_F_RDC : ST_P2_RD;
      ST_F_RDC:   state_nxt = ST_F_RDP;
      ST_F_RDP:   state_nxt = ST_F_RUN;
      ST_F_RUN:   if (status.cell_last) state_nxt = ST_F_DRAIN;
      ST_F_DRAIN: begin
        if (!status.pipe_busy) state_nxt = status.cand_last ? ST_W_RUN : ST_F_RDC;
      end
      ST_W_RUN:   if (status.cell_last) state_nxt = ST_W_DRAIN;
      ST_W_DRAIN: if (!status.wb_busy) state_nxt = ST_LOOK2;
      ST_LOOK2:   state_nxt = ST_RESULT;
      ST_RESULT:  if (status.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_CELL;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR:   cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (cmd_code_t'(in_cmd))
            CMD_WRITE:  cmd.pal_write = 1'b1;
            CMD_LOOKUP: cmd.pix_load = 1'b1;
            default:    cmd.pix_load = 1'b0;
          endcase
        end
      end
      ST_CHECK: begin
        cmd.hit_latch = 1'b1;
        cmd.p1_init   = !status.hit;
      end
      ST_P1_NEAR: cmd.sel = SEL_NEAR;
      ST_P1_FAR:  cmd.sel = SEL_FAR;
      ST_P1_W2:   cmd.cmin_write = 1'b1;
      ST_P1_W3: begin
        cmd.bmax_update = 1'b1;
        cmd.p2_init     = status.ent_last;
        cmd.ent_next    = !status.ent_last;
      end
      ST_P2_CHK: begin
        cmd.cand_check = 1'b1;
        cmd.fill_init  = status.ent_last;
        cmd.ent_next   = !status.ent_last;
      end
      ST_F_RDP:   cmd.pal_cand = 1'b1;
      ST_F_RUN: begin
        cmd.pal_cand   = 1'b1;
        cmd.cell_issue = 1'b1;
      end
      ST_F_DRAIN: begin
        cmd.pal_cand  = 1'b1;
        cmd.cand_done = !status.pipe_busy;
        cmd.wb_init   = !status.pipe_busy && status.cand_last;
      end
      ST_W_RUN:   cmd.wb_issue = 1'b1;
      ST_RESULT:  cmd.out_load = status.out_free;
      default:    cmd.clr_step = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/icm_dist.sv @@
// three-stage weighted squared distance unit
// weighted differences, squares, sum; weights from icm_pkg
`default_nettype none
module icm_dist (
  input  wire logic        clk,
  input  wire logic [7:0]  p_r,
  input  wire logic [7:0]  p_g,
  input  wire logic [7:0]  p_b,
  input  wire logic [7:0]  q_r,
  input  wire logic [7:0]  q_g,
  input  wire logic [7:0]  q_b,
  output logic [icm_pkg::DIST_W-1:0] sq_dist
);
  import icm_pkg::*;

  logic signed [10:0] dr_r, dg_r, db_r;
  logic signed [10:0] dr_nxt, dg_nxt, db_nxt;
  logic signed [21:0] sr_full, sg_full, sb_full;
  logic [DIST_W-1:0]  sr_r, sg_r, sb_r;
  logic [DIST_W-1:0]  sum_r;

  assign dr_nxt = ($signed({3'b000, p_r}) - $signed({3'b000, q_r})) * RED_WT;
  assign dg_nxt = ($signed({3'b000, p_g}) - $signed({3'b000, q_g})) * GREEN_WT;
  assign db_nxt = ($signed({3'b000, p_b}) - $signed({3'b000, q_b})) * BLUE_WT;

  assign sr_full = dr_r * dr_r;
  assign sg_full = dg_r * dg_r;
  assign sb_full = db_r * db_r;

  always_ff @(posedge clk) begin
    dr_r  <= dr_nxt;
    dg_r  <= dg_nxt;
    db_r  <= db_nxt;
    sr_r  <= sr_full[DIST_W-1:0];
    sg_r  <= sg_full[DIST_W-1:0];
    sb_r  <= sb_full[DIST_W-1:0];
    sum_r <= sr_r + sg_r + sb_r;
  end

  assign sq_dist = sum_r;

endmodule
`default_nettype wire

@@ rtl/icm_datapath.sv @@
// datapath of the inverse colormap cache: palette, cell cache, candidate and
// box scratch memories, counters and output register; uses icm_pkg, icm_dist
`default_nettype none
module icm_datapath #(
  parameter int PALETTE_DEPTH   = icm_pkg::PALETTE_DEPTH_DEF,
  parameter int RED_CELL_BITS   = icm_pkg::RED_CELL_BITS_DEF,
  parameter int GREEN_CELL_BITS = icm_pkg::GREEN_CELL_BITS_DEF,
  parameter int BLUE_CELL_BITS  = icm_pkg::BLUE_CELL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [31:0]           in_tdata,
  input  wire logic                  cfg_wen,
  input  wire logic [8:0]            cfg_wdata,
  input  wire icm_pkg::ctrl_cmd_t    cmd,
  output icm_pkg::ctrl_status_t      status,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tuser
);
  import icm_pkg::*;

  localparam int RCB      = RED_CELL_BITS;
  localparam int GCB      = GREEN_CELL_BITS;
  localparam int BCB      = BLUE_CELL_BITS;
  localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
  localparam int RSH      = 8 - RCB;
  localparam int GSH      = 8 - GCB;
  localparam int BSH      = 8 - BCB;
  localparam int RBL      = RCB - 3;
  localparam int GBL      = GCB - 3;
  localparam int BBL      = BCB - 3;
  localparam int CELL_W   = RBL + GBL + BBL;
  localparam int BOX_CELLS = 1 << CELL_W;
  localparam int BOX_AW   = (CELL_W > 0) ? CELL_W : 1;
  localparam int CACHE_AW = RCB + GCB + BCB;
  localparam int CACHE_CELLS = 1 << CACHE_AW;
  localparam logic [RCB-1:0] R_MASK = RCB'((1 << RBL) - 1);
  localparam logic [GCB-1:0] G_MASK = GCB'((1 << GBL) - 1);
  localparam logic [BCB-1:0] B_MASK = BCB'((1 << BBL) - 1);

  // center of a cell on one axis
  function automatic logic [7:0] center(input logic [7:0] c, input int sh);
    return (c << sh) | 8'(((1 << sh) >> 1));
  endfunction

  function automatic logic [7:0] near_pt(input logic [7:0] x, input logic [7:0] lo,
                                         input logic [7:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [7:0] far_pt(input logic [7:0] x, input logic [7:0] lo,
                                        input logic [7:0] hi);
    logic [8:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    if (x < lo) return hi;
    if (x > hi) return lo;
    if (x <= s[8:1]) return hi;
    return lo;
  endfunction

  // memories
  logic [23:0]       pal_mem   [PALETTE_DEPTH];
  logic [8:0]        cache_mem [CACHE_CELLS];
  logic [DIST_W-1:0] cmin_mem  [PALETTE_DEPTH];
  logic [PAL_AW-1:0] cand_mem  [PALETTE_DEPTH];
  logic [DIST_W-1:0] bd_mem    [BOX_CELLS];
  logic [7:0]        bi_mem    [BOX_CELLS];

  logic [23:0]       pal_q;
  logic [8:0]        cache_q;
  logic [DIST_W-1:0] cmin_q;
  logic [PAL_AW-1:0] cand_q;
  logic [DIST_W-1:0] bd_q;
  logic [7:0]        bi_q;

  // control registers
  logic [CACHE_AW-1:0] clr_r;
  logic [8:0]          cc_r;
  logic [PAL_AW-1:0]   ent_r;
  logic [PAL_AW:0]     k_r;
  logic [PAL_AW-1:0]   j_r;
  logic [BOX_AW-1:0]   c_r;
  logic                first_r;
  logic                t1_v_r, t2_v_r, t3_v_r, wb_v_r;
  logic                out_tvalid_r;

  // payload registers
  logic [RCB-1:0]    pix_rc_r;
  logic [GCB-1:0]    pix_gc_r;
  logic [BCB-1:0]    pix_bc_r;
  logic [DIST_W-1:0] bmax_r;
  logic [BOX_AW-1:0] t1_c_r, t2_c_r, t3_c_r, wb_c_r;
  logic              hit_r;
  logic [7:0]        out_idx_r;
  logic              out_hit_r;

  logic [PAL_AW-1:0]   ent_last_v;
  logic [PAL_AW-1:0]   pal_addr;
  logic [CACHE_AW-1:0] pix_addr;
  logic [CACHE_AW-1:0] wb_addr;
  logic                cache_we;
  logic [CACHE_AW-1:0] cache_wa;
  logic [8:0]          cache_wd;
  logic                pal_idx_ok;
  logic [7:0]          lo_r, hi_r, lo_g, hi_g, lo_b, hi_b;
  logic [7:0]          q_r, q_g, q_b;
  logic [DIST_W-1:0]   sq_dist;
  logic                bd_we;
  logic [RCB-1:0]      cr_c, cr_wb;
  logic [GCB-1:0]      cg_c, cg_wb;
  logic [BCB-1:0]      cb_c, cb_wb;

  assign pal_idx_ok = {1'b0, in_tdata[7:0]} < 9'(PALETTE_DEPTH);
  assign pal_addr   = cmd.pal_cand ? cand_q : ent_r;
  assign pix_addr   = {pix_rc_r, pix_gc_r, pix_bc_r};

  always_comb begin
    if (cc_r == 9'd0) begin
      ent_last_v = '0;
    end else if (cc_r > 9'(PALETTE_DEPTH)) begin
      ent_last_v = PAL_AW'(PALETTE_DEPTH - 1);
    end else begin
      ent_last_v = PAL_AW'(cc_r - 9'd1);
    end
  end

  // cell coordinates inside the box, for the issued cell and the write-back
  assign cr_c  = (pix_rc_r & ~R_MASK) | (RCB'(c_r >> (GBL + BBL)) & R_MASK);
  assign cg_c  = (pix_gc_r & ~G_MASK) | (GCB'(c_r >> BBL) & G_MASK);
  assign cb_c  = (pix_bc_r & ~B_MASK) | (BCB'(c_r) & B_MASK);
  assign cr_wb = (pix_rc_r & ~R_MASK) | (RCB'(wb_c_r >> (GBL + BBL)) & R_MASK);
  assign cg_wb = (pix_gc_r & ~G_MASK) | (GCB'(wb_c_r >> BBL) & G_MASK);
  assign cb_wb = (pix_bc_r & ~B_MASK) | (BCB'(wb_c_r) & B_MASK);
  assign wb_addr = {cr_wb, cg_wb, cb_wb};

  // box span as centers of its first and last cells
  assign lo_r = center(8'(pix_rc_r & ~R_MASK), RSH);
  assign hi_r = center(8'(pix_rc_r | R_MASK), RSH);
  assign lo_g = center(8'(pix_gc_r & ~G_MASK), GSH);
  assign hi_g = center(8'(pix_gc_r | G_MASK), GSH);
  assign lo_b = center(8'(pix_bc_r & ~B_MASK), BSH);
  assign hi_b = center(8'(pix_bc_r | B_MASK), BSH);

  always_comb begin
    case (cmd.sel)
      SEL_NEAR: begin
        q_r = near_pt(pal_q[7:0], lo_r, hi_r);
        q_g = near_pt(pal_q[15:8], lo_g, hi_g);
        q_b = near_pt(pal_q[23:16], lo_b, hi_b);
      end
      SEL_FAR: begin
        q_r = far_pt(pal_q[7:0], lo_r, hi_r);
        q_g = far_pt(pal_q[15:8], lo_g, hi_g);
        q_b = far_pt(pal_q[23:16], lo_b, hi_b);
      end
      default: begin
        q_r = center(8'(cr_c), RSH);
        q_g = center(8'(cg_c), GSH);
        q_b = center(8'(cb_c), BSH);
      end
    endcase
  end

  icm_dist u_dist (
    .clk     (clk),
    .p_r     (pal_q[7:0]),
    .p_g     (pal_q[15:8]),
    .p_b     (pal_q[23:16]),
    .q_r     (q_r),
    .q_g     (q_g),
    .q_b     (q_b),
    .sq_dist (sq_dist)
  );

  assign bd_we = t3_v_r && (first_r || (sq_dist < bd_q));

  always_ff @(posedge clk) begin
    if (cmd.pal_write && pal_idx_ok) begin
      pal_mem[in_tdata[PAL_AW-1:0]] <= in_tdata[31:8];
    end
    pal_q <= pal_mem[pal_addr];
  end

  assign cache_we = cmd.clr_step || wb_v_r;
  assign cache_wa = cmd.clr_step ? clr_r : wb_addr;
  assign cache_wd = cmd.clr_step ? 9'd0 : {1'b1, bi_q};

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_wa] <= cache_wd;
    end
    cache_q <= cache_mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cmin_write) begin
      cmin_mem[ent_r] <= sq_dist;
    end
    cmin_q <= cmin_mem[ent_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_check && (cmin_q <= bmax_r)) begin
      cand_mem[k_r[PAL_AW-1:0]] <= ent_r;
    end
    cand_q <= cand_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (bd_we) begin
      bd_mem[t3_c_r] <= sq_dist;
      bi_mem[t3_c_r] <= 8'(cand_q);
    end
    bd_q <= bd_mem[t2_c_r];
    bi_q <= bi_mem[c_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      cc_r         <= 9'd256;
      ent_r        <= '0;
      k_r          <= '0;
      j_r          <= '0;
      c_r          <= '0;
      first_r      <= 1'b0;
      t1_v_r       <= 1'b0;
      t2_v_r       <= 1'b0;
      t3_v_r       <= 1'b0;
      wb_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cfg_wen) cc_r <= cfg_wdata;
      if (cmd.p1_init || cmd.p2_init) begin
        ent_r <= '0;
      end else if (cmd.ent_next) begin
        ent_r <= ent_r + 1'b1;
      end
      if (cmd.p2_init) begin
        k_r <= '0;
      end else if (cmd.cand_check && (cmin_q <= bmax_r)) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.fill_init) begin
        j_r     <= '0;
        first_r <= 1'b1;
      end else if (cmd.cand_done) begin
        j_r     <= j_r + 1'b1;
        first_r <= 1'b0;
      end
      if (cmd.fill_init || cmd.cand_done || cmd.wb_init) begin
        c_r <= '0;
      end else if (cmd.cell_issue || cmd.wb_issue) begin
        c_r <= c_r + 1'b1;
      end
      t1_v_r <= cmd.cell_issue;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      wb_v_r <= cmd.wb_issue;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      pix_rc_r <= RCB'(in_tdata[15:8] >> RSH);
      pix_gc_r <= GCB'(in_tdata[23:16] >> GSH);
      pix_bc_r <= BCB'(in_tdata[31:24] >> BSH);
    end
    if (cmd.p1_init) begin
      bmax_r <= '1;
    end else if (cmd.bmax_update && (sq_dist < bmax_r)) begin
      bmax_r <= sq_dist;
    end
    t1_c_r <= c_r;
    t2_c_r <= t1_c_r;
    t3_c_r <= t2_c_r;
    wb_c_r <= c_r;
    if (cmd.hit_latch) hit_r <= cache_q[8];
    if (cmd.out_load) begin
      out_idx_r <= cache_q[7:0];
      out_hit_r <= hit_r;
    end
  end

  assign status.clr_last  = &clr_r;
  assign status.hit       = cache_q[8];
  assign status.ent_last  = (ent_r == ent_last_v);
  assign status.cell_last = (c_r == BOX_AW'(BOX_CELLS - 1));
  assign status.pipe_busy = t1_v_r || t2_v_r || t3_v_r;
  assign status.cand_last = ({1'b0, j_r} == (k_r - (PAL_AW + 1)'(1)));
  assign status.wb_busy   = wb_v_r;
  assign status.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = out_hit_r;

endmodule
`default_nettype wire

@@ rtl/inverse_colormap_cache_fill_core.sv @@
// Inverse colormap cache with box fill, top level.
// Palette write: one transfer per cycle. Lookup hit: the request runs through the
// LOOK, CHECK and RESULT states, then IDLE takes the next input. Lookup miss: a
// bound pass and a prune pass over the n entries in use, a box fill per surviving
// candidate and a write-back of the box cells; the bound pass and the box fills
// share the distance unit. Reset and the clear command sweep the cell cache, one
// cell a cycle (2^(R+G+B) cells, 65536 by default); no input is taken meanwhile.
`default_nettype none
module inverse_colormap_cache_fill_core #(
  parameter int PALETTE_DEPTH   = icm_pkg::PALETTE_DEPTH_DEF,
  parameter int RED_CELL_BITS   = icm_pkg::RED_CELL_BITS_DEF,
  parameter int GREEN_CELL_BITS = icm_pkg::GREEN_CELL_BITS_DEF,
  parameter int BLUE_CELL_BITS  = icm_pkg::BLUE_CELL_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // entry_index, red_value, green_value, blue_value
  input  wire logic [1:0]  in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // color_index
  output logic             out_tuser,  // was_cached
  input  wire logic        cfg_wen,
  input  wire logic [8:0]  cfg_wdata   // color_count
);
  import icm_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  icm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  icm_datapath #(
    .PALETTE_DEPTH   (PALETTE_DEPTH),
    .RED_CELL_BITS   (RED_CELL_BITS),
    .GREEN_CELL_BITS (GREEN_CELL_BITS),
    .BLUE_CELL_BITS  (BLUE_CELL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// testbench for inverse_colormap_cache_fill_core: palette writes, cache clears and lookups
// with its own nearest-entry predictor and box fill; depends on rtl/icm_pkg.sv and the core
`default_nettype none
module testbench;
  import icm_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unused code, block drops it
  localparam longint CYCLE_LIMIT = 200000000;
  localparam int FAR = 32'h7FFFFFFF;

  typedef struct {
    logic [7:0] color_index;
    logic       was_cached;
  } lookup_answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // entry_index, red_value, green_value, blue_value
  logic [1:0]  in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // color_index
  logic        out_tuser;  // was_cached
  logic        cfg_wen;
  logic [8:0]  cfg_wdata;

  inverse_colormap_cache_fill_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [7:0] pal_red [256];
  logic [7:0] pal_green [256];
  logic [7:0] pal_blue [256];
  logic [8:0] cell_answer [65536];  // index plus 1, zero when uncached
  logic [8:0] count_reg;
  lookup_answer_t pending_answers[$];

  int  mismatches = 0;
  longint cycles = 0;
  int  hold_off_len = 0;
  bit  no_gaps = 0;
  bit  no_stalls = 0;

  // recent pixels, so most lookups land in cached boxes
  logic [23:0] hot_pixels[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("inverse_colormap_cache_fill_core test failed");
      $finish;
    end
  end

  function automatic int entries_used();
    if (count_reg == 0) return 1;
    if (count_reg > 256) return 256;
    return int'(count_reg);
  endfunction

  function automatic int cell_addr(int c0, int c1, int c2);
    return (c0 << 11) | (c1 << 5) | c2;
  endfunction

  function automatic void span_distance(input int x, input int lo, input int hi,
                                        input int w, output int mn, output int mx);
    int mid;
    int t;
    mid = (lo + hi) / 2;
    if (x < lo) begin
      t = (x - lo) * w; mn = t * t;
      t = (x - hi) * w; mx = t * t;
    end else if (x > hi) begin
      t = (x - hi) * w; mn = t * t;
      t = (x - lo) * w; mx = t * t;
    end else begin
      mn = 0;
      t = (x <= mid) ? (x - hi) * w : (x - lo) * w;
      mx = t * t;
    end
  endfunction

  // fill the 4x8x4 box around cell (c0, c1, c2)
  function automatic void fill_box(int c0, int c1, int c2);
    int b0, b1, b2, lo0, lo1, lo2, n, best_max, k;
    int a, b, ta, tb, sa, sb, d, dr, dg, db, e;
    int low_bound [256];
    int cands [256];
    int best_dist [128];
    int best_idx [128];
    b0 = (c0 >> 2) << 2;
    b1 = (c1 >> 3) << 3;
    b2 = (c2 >> 2) << 2;
    lo0 = (b0 << 3) + 4;
    lo1 = (b1 << 2) + 2;
    lo2 = (b2 << 3) + 4;
    n = entries_used();
    best_max = FAR;
    for (int i = 0; i < n; i++) begin
      span_distance(pal_red[i], lo0, lo0 + 24, 2, a, b);
      span_distance(pal_green[i], lo1, lo1 + 28, 3, ta, tb);
      span_distance(pal_blue[i], lo2, lo2 + 24, 1, sa, sb);
      low_bound[i] = a + ta + sa;
      if (b + tb + sb < best_max) best_max = b + tb + sb;
    end
    k = 0;
    for (int i = 0; i < n; i++)
      if (low_bound[i] <= best_max) begin
        cands[k] = i;
        k++;
      end
    for (int c = 0; c < 128; c++) begin
      best_dist[c] = FAR;
      best_idx[c] = 0;
    end
    // exact squared distance at each cell center; ties keep the lower index
    for (int j = 0; j < k; j++) begin
      e = cands[j];
      for (int i0 = 0; i0 < 4; i0++)
        for (int i1 = 0; i1 < 8; i1++)
          for (int i2 = 0; i2 < 4; i2++) begin
            dr = (lo0 + 8 * i0 - int'(pal_red[e])) * 2;
            dg = (lo1 + 4 * i1 - int'(pal_green[e])) * 3;
            db = lo2 + 8 * i2 - int'(pal_blue[e]);
            d = dr * dr + dg * dg + db * db;
            if (d < best_dist[i0 * 32 + i1 * 4 + i2]) begin
              best_dist[i0 * 32 + i1 * 4 + i2] = d;
              best_idx[i0 * 32 + i1 * 4 + i2] = e;
            end
          end
    end
    for (int i0 = 0; i0 < 4; i0++)
      for (int i1 = 0; i1 < 8; i1++)
        for (int i2 = 0; i2 < 4; i2++)
          cell_answer[cell_addr(b0 + i0, b1 + i1, b2 + i2)] =
            9'(best_idx[i0 * 32 + i1 * 4 + i2] + 1);
  endfunction

  function automatic void apply_item(logic [1:0] cmd, logic [7:0] idx,
                                     logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int addr;
    lookup_answer_t ans;
    case (cmd)
      CMD_WRITE: begin
        pal_red[idx] = r;
        pal_green[idx] = g;
        pal_blue[idx] = b;
      end
      CMD_CLEAR: begin
        foreach (cell_answer[i]) cell_answer[i] = '0;
      end
      CMD_LOOKUP: begin
        addr = cell_addr(r >> 3, g >> 2, b >> 3);
        ans.was_cached = (cell_answer[addr] != 0);
        if (!ans.was_cached) fill_box(r >> 3, g >> 2, b >> 3);
        ans.color_index = 8'(cell_answer[addr] - 9'd1);
        pending_answers.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic send_item(logic [1:0] cmd, logic [7:0] idx,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    bit ready_seen;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {b, g, r, idx};
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    apply_item(cmd, idx, r, g, b);
  endtask

  // receiver side: stalls, long hold-off on request, checks each transfer
  initial begin : result_checker
    int stall;
    bit got;
    logic [7:0] got_index;
    logic got_cached;
    lookup_answer_t want;
    @(posedge rst_n);
    forever begin
      stall = no_stalls ? 0 : $urandom_range(0, 8);
      if (hold_off_len > 0) begin
        stall = hold_off_len;
        hold_off_len = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_tvalid;
        got_index = out_tdata;
        got_cached = out_tuser;
        @(posedge clk);
      end while (!got);
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result, color_index", got_index, -1);
      end else begin
        want = pending_answers.pop_front();
        if (got_index !== want.color_index)
          report_mismatch("color_index", got_index, want.color_index);
        if (got_cached !== want.was_cached)
          report_mismatch("was_cached", got_cached, want.was_cached);
      end
    end
  end

  function automatic logic [23:0] pick_pixel();
    logic [23:0] p;
    if (hot_pixels.size() > 0 && $urandom_range(0, 99) < 75) begin
      p = hot_pixels[$urandom_range(0, hot_pixels.size() - 1)];
      p = p ^ 24'($urandom_range(0, 3)) ^ (24'($urandom_range(0, 1)) << 8);
    end else begin
      p = 24'($urandom);
      hot_pixels.push_back(p);
      if (hot_pixels.size() > 24) void'(hot_pixels.pop_front());
    end
    return p;
  endfunction

  task automatic lookup(logic [23:0] p);
    send_item(CMD_LOOKUP, 8'($urandom), p[7:0], p[15:8], p[23:16]);
  endtask

  // a lookup cannot finish before a clear sweep or a fill, so its result means idle
  task automatic wait_idle();
    lookup(24'($urandom));
    in_tvalid <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_color_count(logic [8:0] value);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    count_reg = value;
  endtask

  task automatic test_palette_load();
    send_item(CMD_WRITE, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(CMD_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
    for (int i = 1; i < 255; i++)
      send_item(CMD_WRITE, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    lookup(24'h000000);
    lookup(24'hFFFFFF);
    lookup(24'hFF00FF);
    lookup(24'h00FF00);
    lookup(24'h000000);
    lookup(24'hFFFFFF);
    send_item(CMD_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    lookup(24'h808080);
    // stale answers survive a palette change until cleared
    send_item(CMD_WRITE, 8'd0, 8'h80, 8'h80, 8'h80);
    lookup(24'h808080);
    send_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
    lookup(24'h808080);
    lookup(24'h7F7F7F);
    set_color_count(9'd0);
    lookup(24'h102030);
    set_color_count(9'd511);
    lookup(24'hC0A040);
    set_color_count(9'd1);
    lookup(24'h40A0C0);
    set_color_count(9'd256);
  endtask

  task automatic test_pressure();
    wait_idle();
    hold_off_len = 400;
    no_gaps = 1;
    for (int i = 0; i < 20; i++) lookup(24'h808080 ^ 24'($urandom_range(0, 7)));
    no_gaps = 0;
  endtask

  task automatic test_random(int phases, int per_phase);
    int roll;
    logic [23:0] p;
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == 1) set_color_count(9'd256);
      else if (ph == 2) set_color_count(9'd1);
      else set_color_count(9'($urandom_range(2, 24)));
      no_gaps = (ph % 4 == 3);
      no_stalls = (ph % 4 == 3);
      if (ph == 3 || ph == 6) send_item(CMD_CLEAR, 8'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom));
      for (int i = 0; i < per_phase; i++) begin
        roll = $urandom_range(0, 99);
        p = 24'($urandom);
        if (roll < 12)
          send_item(CMD_WRITE, 8'($urandom), p[7:0], p[15:8], p[23:16]);
        else if (roll < 14)
          send_item(CMD_NONE, 8'($urandom), p[7:0], p[15:8], p[23:16]);
        else
          lookup(ph == 1 && roll > 40 && hot_pixels.size() > 0 ?
                 hot_pixels[0] : pick_pixel());
      end
    end
    no_gaps = 0;
    no_stalls = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_WRITE;
    out_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    count_reg = 9'd256;
    foreach (cell_answer[i]) cell_answer[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_palette_load();
    test_directed();
    test_pressure();
    test_random(8, 160);
    in_tvalid <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("inverse_colormap_cache_fill_core test passed");
    end else begin
      $display("inverse_colormap_cache_fill_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
